FILE: design/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg: shared types and constants of the multiset table
// Capacity, field widths, action codes, payload structs and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mst_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ACT_W    = 2;
   localparam int VAL_W    = 32;
   localparam int OCC_W    = 7;

   localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;
   localparam logic [ACT_W-1:0] ACT_COUNT  = 2'd3;

   typedef struct packed {
      logic [ACT_W-1:0]        action;
      logic signed [VAL_W-1:0] value;
   } mst_req_type;

   typedef struct packed {
      logic             hit;
      logic [OCC_W-1:0] occurrences;
      logic [OCC_W-1:0] total_size;
      logic             is_empty;
      logic             overflow;
   } mst_rsp_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic [CNT_W-1:0]        mult;
   } mst_entry_type;

   typedef struct packed {
      logic take;
      logic scan;
      logic exec;
      logic shift;
      logic publish;
   } mst_cmd_type;

   typedef struct packed {
      logic table_empty;
      logic match;
      logic at_last;
      logic need_shift;
      logic out_free;
   } mst_sts_type;

endpackage

`default_nettype wire

FILE: design/mst_datapath.sv
// ----------------------------------------------------------------------------
// mst_datapath: table memory, counters and result registers
// Holds the distinct-value table in a one-read one-write memory, scans it
// one entry per cycle, applies the action and compacts when a value's last copy goes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mst_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  mst_pkg::mst_cmd_type cmd,
   output mst_pkg::mst_sts_type sts,
   input  mst_pkg::mst_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mst_pkg::mst_rsp_type rsp_data
);
   import mst_pkg::*;

   mst_entry_type    entry_mem [CAPACITY];
   mst_entry_type    rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   mst_entry_type    wr_data;

   mst_req_type      req_ff, req_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             found_ff, found_in;
   logic [CNT_W-1:0] mult_ff, mult_in;
   logic [CNT_W-1:0] distinct_ff, distinct_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic             res_hit_ff, res_hit_in;
   logic             res_ovf_ff, res_ovf_in;
   logic [CNT_W-1:0] res_occ_ff, res_occ_in;
   logic             rsp_valid_ff, rsp_valid_in;
   mst_rsp_type      rsp_data_ff, rsp_data_in;

   logic             full;
   logic             match;
   logic             at_last;
   logic [CNT_W-1:0] idx_next;

   assign full     = total_ff == CNT_W'(CAPACITY);
   assign match    = rd_data_ff.value == req_ff.value;
   assign idx_next = CNT_W'(idx_ff) + CNT_W'(1);
   assign at_last  = idx_next >= distinct_ff;

   assign sts.table_empty = distinct_ff == '0;
   assign sts.match       = match;
   assign sts.at_last     = at_last;
   assign sts.need_shift  = (req_ff.action == ACT_REMOVE) && found_ff
                            && (mult_ff <= CNT_W'(1));
   assign sts.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      req_in      = req_ff;
      idx_in      = idx_ff;
      found_in    = found_ff;
      mult_in     = mult_ff;
      distinct_in = distinct_ff;
      total_in    = total_ff;
      res_hit_in  = res_hit_ff;
      res_ovf_in  = res_ovf_ff;
      res_occ_in  = res_occ_ff;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = idx_ff;
      wr_data     = '{value: req_ff.value, mult: mult_ff};

      if (cmd.take) begin
         req_in   = req_data;
         idx_in   = '0;
         found_in = 1'b0;
         mult_in  = '0;
      end

      if (cmd.scan) begin
         rd_addr = idx_ff + IDX_W'(1);
         if (match) begin
            found_in = 1'b1;
            mult_in  = rd_data_ff.mult;
         end else if (!at_last) begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end

      if (cmd.exec) begin
         rd_addr    = idx_ff + IDX_W'(1);
         res_hit_in = 1'b0;
         res_ovf_in = 1'b0;
         res_occ_in = '0;
         case (req_ff.action)
            ACT_ADD: begin
               if (full) begin
                  res_ovf_in = 1'b1;
                  res_occ_in = found_ff ? mult_ff : '0;
               end else if (found_ff) begin
                  wr_en        = 1'b1;
                  wr_data.mult = mult_ff + CNT_W'(1);
                  total_in     = total_ff + CNT_W'(1);
                  res_hit_in   = 1'b1;
                  res_occ_in   = mult_ff + CNT_W'(1);
               end else if (distinct_ff < CNT_W'(CAPACITY)) begin
                  wr_en        = 1'b1;
                  wr_addr      = IDX_W'(distinct_ff);
                  wr_data.mult = CNT_W'(1);
                  distinct_in  = distinct_ff + CNT_W'(1);
                  total_in     = total_ff + CNT_W'(1);
                  res_hit_in   = 1'b1;
                  res_occ_in   = CNT_W'(1);
               end else begin
                  res_ovf_in = 1'b1;
               end
            end
            ACT_REMOVE: begin
               if (found_ff) begin
                  res_hit_in = 1'b1;
                  if (total_ff != '0) begin
                     total_in = total_ff - CNT_W'(1);
                  end
                  if (mult_ff > CNT_W'(1)) begin
                     wr_en        = 1'b1;
                     wr_data.mult = mult_ff - CNT_W'(1);
                     res_occ_in   = mult_ff - CNT_W'(1);
                  end
               end
            end
            default: begin
               res_hit_in = found_ff;
               res_occ_in = found_ff ? mult_ff : '0;
            end
         endcase
      end

      if (cmd.shift) begin
         rd_addr = idx_ff + IDX_W'(2);
         if (!at_last) begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data_ff;
            idx_in  = idx_ff + IDX_W'(1);
         end else begin
            distinct_in = distinct_ff - CNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{hit:         res_hit_ff,
                          occurrences: OCC_W'(res_occ_ff),
                          total_size:  OCC_W'(total_ff),
                          is_empty:    total_ff == '0,
                          overflow:    res_ovf_ff};
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         distinct_ff  <= '0;
         total_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         distinct_ff  <= distinct_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      mult_ff     <= mult_in;
      res_hit_ff  <= res_hit_in;
      res_ovf_ff  <= res_ovf_in;
      res_occ_ff  <= res_occ_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_distinct_le_total: assert property (@(posedge clock) disable iff (reset)
      !cmd.shift |-> distinct_ff <= total_ff)
      else $error("distinct count exceeds total count");

   a_total_le_cap: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(CAPACITY))
      else $error("total count exceeds capacity");

   a_write_in_table: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> CNT_W'(wr_addr) <= distinct_ff)
      else $error("write beyond the end of the table");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.scan, cmd.exec, cmd.shift, cmd.publish}))
      else $error("more than one command at once");

   a_add_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && req_ff.action == ACT_ADD && res_hit_in)
      |=> total_ff == $past(total_ff) + CNT_W'(1))
      else $error("accepted add did not grow the total");
`endif

endmodule

`default_nettype wire

FILE: design/mst_ctrl.sv
// ----------------------------------------------------------------------------
// mst_ctrl: sequencing state machine of the multiset table
// Steps each item through accept, table scan (not on an empty table), update,
// compaction (after a last-copy remove) and hand-off to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mst_pkg::mst_sts_type sts,
   output mst_pkg::mst_cmd_type cmd
);
   import mst_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_SHIFT = 3'd3;
   localparam logic [2:0] ST_POST  = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = sts.table_empty ? ST_EXEC : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.match || sts.at_last) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.need_shift ? ST_SHIFT : ST_POST;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (sts.at_last) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/multiset_table_top.sv
// ----------------------------------------------------------------------------
// multiset_table_top: fixed-capacity bag of signed 32-bit values
// Request beat: action (add, remove one, search, count) and value.
// Response beat: hit, occurrences, total_size, is_empty, overflow; one
// response beat for every request beat, in order.
// Both channels are valid/ready. One request is in work at a time; req_ready
// is high only while the sequencer waits for a request.
// Steps per request: accept, scan, update, compaction if needed, hand-off. The
// scan reads one table entry per cycle from the table memory until the value
// is found or the distinct entries run out. Removing the last occurrence of a
// value compacts the table, one entry moved per cycle.
// An empty table skips the scan.
// The result sits in an output register; the next request is accepted while
// it waits. A stalled receiver holds the sequencer only at hand-off.
// Reset (synchronous, active high) empties the bag at once; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multiset_table_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mst_pkg::mst_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mst_pkg::mst_rsp_type rsp_data
);
   import mst_pkg::*;

   mst_cmd_type cmd;
   mst_sts_type sts;

   mst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mst_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
